// ===== rtl/cfp_pkg.sv =====
// ----------------------------------------------------------------------------
// cfp_pkg: shared types, codes and CRC tables
// Item and result structs, operation codes, register indexes, and the
// reflected CRC-32 byte table with its top-byte inverse.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cfp_pkg;

  localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
  localparam logic [31:0] FWD_RESET  = 32'hFFFFFFFF;
  localparam logic [31:0] BWD_RESET  = 32'h00000000;

  // Operation codes
  localparam logic [1:0] OP_FORWARD  = 2'd0;
  localparam logic [1:0] OP_BACKWARD = 2'd1;
  localparam logic [1:0] OP_FINISH   = 2'd2;
  localparam logic [1:0] OP_NOP      = 2'd3;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_FORWARD_START   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BACKWARD_TARGET = 2'd1;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] data_byte;
  } cfp_in_t;

  typedef struct packed {
    logic [31:0] forward_crc;
    logic [31:0] backward_crc;
    logic [31:0] patch_word;
    logic        patch_ready;
  } cfp_out_t;

  // Classified item handed from front to back
  typedef struct packed {
    logic       is_fwd;
    logic       is_bwd;
    logic       is_fin;
    logic [7:0] data;
  } cfp_cmd_t;

  typedef logic [31:0] crc_tab_t [256];
  typedef logic [7:0]  inv_tab_t [256];

  function automatic logic [31:0] tab_entry(input logic [7:0] k);
    logic [31:0] v;
    v = {24'd0, k};
    for (int b = 0; b < 8; b++) begin
      v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
    end
    return v;
  endfunction

  function automatic crc_tab_t build_tab();
    crc_tab_t t;
    for (int k = 0; k < 256; k++) begin
      t[k] = tab_entry(8'(k));
    end
    return t;
  endfunction

  // Top byte of each table entry is unique, so this map is one to one
  function automatic inv_tab_t build_inv();
    inv_tab_t t;
    logic [31:0] e;
    for (int k = 0; k < 256; k++) begin
      e = tab_entry(8'(k));
      t[e[31:24]] = 8'(k);
    end
    return t;
  endfunction

  localparam crc_tab_t CRC_TAB = build_tab();
  localparam inv_tab_t CRC_INV = build_inv();

endpackage

`default_nettype wire

// ===== rtl/cfp_front.sv =====
// ----------------------------------------------------------------------------
// cfp_front: item intake and classification
// Accepts items, decodes the operation and holds them in a two-entry queue
// for the execution side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cfp_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  output logic                  item_ready,
  input  wire cfp_pkg::cfp_in_t item,
  output logic                  q_valid,
  output cfp_pkg::cfp_cmd_t     q_cmd,
  input  wire logic             q_pop
);

  cfp_pkg::cfp_cmd_t entry [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        count;
  cfp_pkg::cfp_cmd_t cmd;
  logic              push;
  logic              pop;

  // Decode the operation
  always_comb begin
    cmd.is_fwd = (item.operation == cfp_pkg::OP_FORWARD);
    cmd.is_bwd = (item.operation == cfp_pkg::OP_BACKWARD);
    cmd.is_fin = (item.operation == cfp_pkg::OP_FINISH);
    cmd.data   = item.data_byte;
  end

  assign item_ready = (count != 2'd2);
  assign push       = item_valid && item_ready;
  assign q_valid    = (count != 2'd0);
  assign pop        = q_pop && q_valid;
  assign q_cmd      = entry[rd_ptr];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= cmd;
    end
  end

  // Queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cfp_back.sv =====
// ----------------------------------------------------------------------------
// cfp_back: CRC execution and result register
// Runs forward and backward byte steps, sequences the patch derivation
// over eight steps and drives the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cfp_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_valid,
  input  wire cfp_pkg::cfp_cmd_t q_cmd,
  output logic                   q_pop,
  input  wire logic [31:0]       forward_start,
  input  wire logic [31:0]       backward_target,
  output logic                   result_valid,
  input  wire logic              result_ready,
  output cfp_pkg::cfp_out_t      result
);

  logic [31:0] fwd_reg;
  logic [31:0] bwd_reg;
  logic        busy;
  logic [2:0]  cnt;
  logic [31:0] pre;
  logic [31:0] post;
  logic [31:0] idx;
  logic [31:0] word;

  logic        out_free;
  logic        step_en;
  logic        last_step;
  logic [31:0] fwd_next;
  logic [31:0] bwd_next;
  logic [7:0]  bwd_k;
  logic [31:0] bwd_x;
  logic [7:0]  post_k;
  logic [31:0] post_x;
  logic [31:0] post_next;
  logic [31:0] pre_next;
  logic [31:0] idx_next;
  logic [31:0] word_next;

  assign out_free  = !result_valid || result_ready;
  assign q_pop     = q_valid && !busy && out_free;
  assign last_step = (cnt == 3'd7);
  assign step_en   = busy && (!last_step || out_free);

  // Single byte steps
  always_comb begin
    fwd_next = cfp_pkg::CRC_TAB[fwd_reg[7:0] ^ q_cmd.data] ^ (fwd_reg >> 8);
    bwd_k    = cfp_pkg::CRC_INV[bwd_reg[31:24]];
    bwd_x    = bwd_reg ^ cfp_pkg::CRC_TAB[bwd_k];
    bwd_next = {bwd_x[23:0], bwd_k ^ q_cmd.data};
  end

  // Patch sequencer step: four inverse steps, then four forward steps
  always_comb begin
    post_k    = cfp_pkg::CRC_INV[post[31:24]];
    post_x    = post ^ cfp_pkg::CRC_TAB[post_k];
    post_next = post;
    pre_next  = pre;
    idx_next  = idx;
    word_next = word;
    if (!cnt[2]) begin
      post_next = {post_x[23:0], 8'h00};
      idx_next  = {idx[23:0], post_k};
    end else begin
      pre_next  = (pre >> 8) ^ cfp_pkg::CRC_TAB[idx[7:0]];
      word_next = {pre[7:0] ^ idx[7:0], word[31:8]};
      idx_next  = idx >> 8;
    end
  end

  // Sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 3'd0;
    end else if (q_pop && q_cmd.is_fin) begin
      busy <= 1'b1;
      cnt  <= 3'd0;
    end else if (step_en) begin
      cnt <= cnt + 3'd1;
      if (last_step) busy <= 1'b0;
    end
  end

  // Sequencer data
  always_ff @(posedge clk) begin
    if (q_pop && q_cmd.is_fin) begin
      pre  <= fwd_reg;
      post <= bwd_reg;
      idx  <= 32'd0;
      word <= 32'd0;
    end else if (step_en) begin
      pre  <= pre_next;
      post <= post_next;
      idx  <= idx_next;
      word <= word_next;
    end
  end

  // Running CRC registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_reg <= cfp_pkg::FWD_RESET;
      bwd_reg <= cfp_pkg::BWD_RESET;
    end else if (q_pop) begin
      if (q_cmd.is_fwd) fwd_reg <= fwd_next;
      if (q_cmd.is_bwd) bwd_reg <= bwd_next;
      if (q_cmd.is_fin) begin
        fwd_reg <= forward_start;
        bwd_reg <= backward_target;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if ((q_pop && !q_cmd.is_fin) || (step_en && last_step)) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && !q_cmd.is_fin) begin
      result.forward_crc  <= q_cmd.is_fwd ? fwd_next : fwd_reg;
      result.backward_crc <= q_cmd.is_bwd ? bwd_next : bwd_reg;
      result.patch_word   <= 32'd0;
      result.patch_ready  <= 1'b0;
    end else if (step_en && last_step) begin
      result.forward_crc  <= fwd_reg;
      result.backward_crc <= bwd_reg;
      result.patch_word   <= word_next;
      result.patch_ready  <= 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/crc32_forcing_patch_top.sv =====
// ----------------------------------------------------------------------------
// crc32_forcing_patch_top: CRC-32 forcing patch unit
// Forward and backward reflected CRC-32 registers and patch derivation.
// ----------------------------------------------------------------------------
// Usage:
//   item channel (item_valid/item_ready/item): operation and data_byte.
//   Forward items run the CRC over a prefix byte; backward items un-run it
//   over a suffix byte (last byte first); finish emits the patch word and
//   reloads both registers from forward_start and backward_target.
//   result channel (result_valid/result_ready/result): one result per item.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready;
//   index 0 forward_start, index 1 backward_target, others ignored. Writes
//   apply at the next finish.
// Throughput and sequencing:
//   Byte items: the result register loads when the item is popped; one item
//   per cycle while the result is not stalled and no finish is running.
//   Finish: popping it starts the patch sequencer, then eight table steps
//   run, one per cycle, the last one held while the result is stalled. Items
//   queued behind it wait until the sequencer is done.
// Reset: clears the queue and result register, restores both start values.
// Stall: a stalled result holds; the two-entry queue fills, then item_ready
//   drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module crc32_forcing_patch_top (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               item_valid,
  output logic                                    item_ready,
  input  wire cfp_pkg::cfp_in_t                   item,
  output logic                                    result_valid,
  input  wire logic                               result_ready,
  output cfp_pkg::cfp_out_t                       result,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [cfp_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [31:0]                        cfg_data
);

  logic              q_valid;
  logic              q_pop;
  cfp_pkg::cfp_cmd_t q_cmd;
  logic [31:0]       forward_start;
  logic [31:0]       backward_target;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      forward_start   <= cfp_pkg::FWD_RESET;
      backward_target <= cfp_pkg::BWD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cfp_pkg::REG_FORWARD_START:   forward_start   <= cfg_data;
        cfp_pkg::REG_BACKWARD_TARGET: backward_target <= cfg_data;
        default: ;
      endcase
    end
  end

  cfp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd),
    .q_pop      (q_pop)
  );

  cfp_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (q_valid),
    .q_cmd           (q_cmd),
    .q_pop           (q_pop),
    .forward_start   (forward_start),
    .backward_target (backward_target),
    .result_valid    (result_valid),
    .result_ready    (result_ready),
    .result          (result)
  );

endmodule

`default_nettype wire

// ===== rtl/cfp_checker.sv =====
// ----------------------------------------------------------------------------
// cfp_checker: port-level checks for the forcing patch unit
// Watches the top level's ports and flags result channel misbehavior.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cfp_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              result_valid,
  input wire logic              result_ready,
  input wire cfp_pkg::cfp_out_t result
);

  // A stalled result holds its payload
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

  // Only a finish result carries a patch word
  a_patch_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.patch_ready |-> result.patch_word == 32'd0)
    else $error("patch word set on non-finish result");

  // No result is valid right after reset
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !result_valid)
    else $error("result right after reset");

endmodule

bind crc32_forcing_patch_top cfp_checker u_cfp_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

`default_nettype wire
